// ===== sv/dlrs_pkg.sv =====
// Shared constants, types and GF(16) arithmetic for the dual-lane RS(15,11) encoder.
`default_nettype none
package dlrs_pkg;

  localparam int DATA_SYMBOLS = 11;
  localparam int PAR_SYMS     = 4;
  localparam int SYM_W        = 4;
  localparam int BYTE_W       = 2 * SYM_W;
  localparam int CNT_W        = $clog2(DATA_SYMBOLS + 1);
  localparam int PCNT_W       = $clog2(PAR_SYMS + 1);
  localparam int PIDX_W       = $clog2(PAR_SYMS);

  // x^4 = x + 1 for the primitive polynomial x^4 + x + 1.
  localparam logic [SYM_W-1:0] GF_POLY = 4'h3;

  // Generator coefficients alpha^10, alpha^3, alpha^6, alpha^13 for parity taps 0 to 3.
  localparam logic [SYM_W-1:0] GEN_COEF [PAR_SYMS] = '{4'd7, 4'd8, 4'd12, 4'd13};

  typedef logic [PAR_SYMS-1:0][SYM_W-1:0] par_vec_t;

  typedef struct packed {
    logic accept;
    logic last;
  } ctrl_t;

  function automatic logic [SYM_W-1:0] gf_mul(input logic [SYM_W-1:0] a,
                                               input logic [SYM_W-1:0] b);
    logic [SYM_W-1:0] acc;
    logic [SYM_W-1:0] sh;
    acc = '0;
    sh  = a;
    for (int i = 0; i < SYM_W; i++) begin
      if (b[i]) begin
        acc = acc ^ sh;
      end
      sh = {sh[SYM_W-2:0], 1'b0} ^ (sh[SYM_W-1] ? GF_POLY : '0);
    end
    return acc;
  endfunction

endpackage
`default_nettype wire

// ===== sv/dlrs_lane.sv =====
// One 4-bit lane: the parity shift register of a systematic RS(15,11) encoder.
`default_nettype none
module dlrs_lane (
  input  wire logic                     clk,
  input  wire logic                     rst,
  input  wire logic                     en,
  input  wire logic                     clear,
  input  wire logic [dlrs_pkg::SYM_W-1:0] sym,
  output dlrs_pkg::par_vec_t            parity_next
);
  import dlrs_pkg::*;

  par_vec_t         parity;
  logic [SYM_W-1:0] fb;

  assign fb = sym ^ parity[PAR_SYMS-1];

  always_comb begin
    parity_next[0] = gf_mul(GEN_COEF[0], fb);
    for (int j = 1; j < PAR_SYMS; j++) begin
      parity_next[j] = parity[j-1] ^ gf_mul(GEN_COEF[j], fb);
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      parity <= '0;
    end else if (en) begin
      parity <= clear ? '0 : parity_next;
    end
  end

endmodule
`default_nettype wire

// ===== sv/dlrs_merge.sv =====
// Output stage: packs the two lanes, passes data through and emits the parity bytes.
`default_nettype none
module dlrs_merge (
  input  wire logic                        clk,
  input  wire logic                        rst,
  input  wire dlrs_pkg::ctrl_t             ctrl,
  input  wire logic [dlrs_pkg::BYTE_W-1:0] data_byte,
  input  wire dlrs_pkg::par_vec_t          par_low,
  input  wire dlrs_pkg::par_vec_t          par_high,
  input  wire logic                        out_stall,
  output logic                             in_stall,
  output logic                             out_valid,
  output logic [dlrs_pkg::BYTE_W-1:0]      code_byte,
  output logic                             block_end
);
  import dlrs_pkg::*;

  logic [PCNT_W-1:0] pend_cnt;
  logic [PCNT_W-1:0] pend_dec;
  logic [PIDX_W-1:0] pend_idx;
  par_vec_t          buf_low;
  par_vec_t          buf_high;
  logic              out_free;

  assign out_free = !out_valid || !out_stall;
  assign in_stall = !(out_free && (pend_cnt == '0));
  assign pend_dec = pend_cnt - PCNT_W'(1);
  assign pend_idx = pend_dec[PIDX_W-1:0];

  // Control registers.
  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
      pend_cnt  <= '0;
    end else if (out_free) begin
      if (ctrl.accept) begin
        out_valid <= 1'b1;
        pend_cnt  <= ctrl.last ? PCNT_W'(PAR_SYMS) : '0;
      end else if (pend_cnt != '0) begin
        out_valid <= 1'b1;
        pend_cnt  <= pend_dec;
      end else begin
        out_valid <= 1'b0;
      end
    end
  end

  // Payload registers; the parity snapshot is the state after the last data byte.
  always_ff @(posedge clk) begin
    if (out_free) begin
      if (ctrl.accept) begin
        code_byte <= data_byte;
        block_end <= 1'b0;
        if (ctrl.last) begin
          buf_low  <= par_low;
          buf_high <= par_high;
        end
      end else if (pend_cnt != '0) begin
        code_byte <= {buf_high[pend_idx], buf_low[pend_idx]};
        block_end <= (pend_cnt == PCNT_W'(1));
      end
    end
  end

endmodule
`default_nettype wire

// ===== sv/dual_lane_rs15_11_encoder.sv =====
// A data byte appears at the output in the cycle after its transfer. Bytes are
// taken at one byte per cycle while the output is not stalled; a codeword of
// DATA_SYMBOLS data bytes leaves as DATA_SYMBOLS + 4 bytes, and the input stalls
// while the parity bytes b3 to b0 are loaded into the output register.
// Reset (synchronous, rst high) clears both parity lanes, the symbol count and the
// output valid flag.
`default_nettype none
module dual_lane_rs15_11_encoder (
  input  wire logic                        clk,
  input  wire logic                        rst,
  input  wire logic                        in_valid,
  output logic                             in_stall,
  input  wire logic [dlrs_pkg::BYTE_W-1:0] data_byte,
  output logic                             out_valid,
  input  wire logic                        out_stall,
  output logic [dlrs_pkg::BYTE_W-1:0]      code_byte,
  output logic                             block_end
);
  import dlrs_pkg::*;

  logic [CNT_W-1:0] symbol_count;
  ctrl_t            ctrl;
  par_vec_t         par_low_next;
  par_vec_t         par_high_next;

  assign ctrl.accept = in_valid && !in_stall;
  assign ctrl.last   = (symbol_count == CNT_W'(DATA_SYMBOLS - 1));

  always_ff @(posedge clk) begin
    if (rst) begin
      symbol_count <= '0;
    end else if (ctrl.accept) begin
      symbol_count <= ctrl.last ? '0 : symbol_count + CNT_W'(1);
    end
  end

  dlrs_lane u_lane_low (
    .clk         (clk),
    .rst         (rst),
    .en          (ctrl.accept),
    .clear       (ctrl.last),
    .sym         (data_byte[SYM_W-1:0]),
    .parity_next (par_low_next)
  );

  dlrs_lane u_lane_high (
    .clk         (clk),
    .rst         (rst),
    .en          (ctrl.accept),
    .clear       (ctrl.last),
    .sym         (data_byte[BYTE_W-1:SYM_W]),
    .parity_next (par_high_next)
  );

  dlrs_merge u_merge (
    .clk       (clk),
    .rst       (rst),
    .ctrl      (ctrl),
    .data_byte (data_byte),
    .par_low   (par_low_next),
    .par_high  (par_high_next),
    .out_stall (out_stall),
    .in_stall  (in_stall),
    .out_valid (out_valid),
    .code_byte (code_byte),
    .block_end (block_end)
  );

endmodule
`default_nettype wire

// ===== sv/dlrs_checker.sv =====
// Port-level checker for the dual-lane RS(15,11) encoder, bound to the top level.
`default_nettype none
module dlrs_checker (
  input wire logic       clk,
  input wire logic       rst,
  input wire logic       in_valid,
  input wire logic       in_stall,
  input wire logic [7:0] data_byte,
  input wire logic       out_valid,
  input wire logic       out_stall,
  input wire logic [7:0] code_byte,
  input wire logic       block_end
);

  // A stalled result holds.
  a_out_hold: assert property (@(posedge clk) disable iff (rst)
    out_valid && out_stall |=> out_valid && $stable(code_byte) && $stable(block_end))
    else $error("stalled output changed");

  // The output register is empty right after reset.
  a_reset_empty: assert property (@(posedge clk)
    rst |=> !out_valid)
    else $error("output valid after reset");

  // Every input transfer shows its pass-through byte in the cycle after it.
  a_pass_through: assert property (@(posedge clk) disable iff (rst)
    in_valid && !in_stall |=> out_valid && (code_byte == $past(data_byte)) && !block_end)
    else $error("data byte not passed through");

  // The last parity byte is loaded while the input is held off for parity emission.
  a_end_stalls: assert property (@(posedge clk) disable iff (rst)
    out_valid && block_end && !$past(out_valid && block_end) |-> $past(in_stall))
    else $error("input taken during parity emission");

endmodule

bind dual_lane_rs15_11_encoder dlrs_checker u_dlrs_checker (
  .clk       (clk),
  .rst       (rst),
  .in_valid  (in_valid),
  .in_stall  (in_stall),
  .data_byte (data_byte),
  .out_valid (out_valid),
  .out_stall (out_stall),
  .code_byte (code_byte),
  .block_end (block_end)
);
`default_nettype wire

// ===== tb/tb_dual_lane_rs15_11_encoder.sv =====
// Self-checking testbench for the dual-lane RS(15,11) encoder with a predictor and scoreboard.
module tb_dual_lane_rs15_11_encoder;
  timeunit 1ns;
  timeprecision 1ps;

  import dlrs_pkg::*;

  localparam int CYCLE_LIMIT   = 200000;
  localparam int LONG_HOLD     = 80;
  localparam int DRAIN_CYCLES  = 10;
  localparam int RANDOM_ITEMS  = 98;

  // GF(16) antilog and log tables for x^4 + x + 1; the log of zero is never used.
  localparam logic [SYM_W-1:0] FIELD_EXP [16] =
    '{4'd1, 4'd2, 4'd4, 4'd8, 4'd3, 4'd6, 4'd12, 4'd11,
      4'd5, 4'd10, 4'd7, 4'd14, 4'd15, 4'd13, 4'd9, 4'd0};
  localparam int FIELD_LOG [16] = '{0, 0, 1, 4, 2, 8, 5, 10, 3, 14, 9, 7, 6, 13, 11, 12};
  localparam int ROOT_LOG [PAR_SYMS] = '{10, 3, 6, 13};

  class rs_scoreboard;
    par_vec_t low_lane;
    par_vec_t high_lane;
    int unsigned data_count;
    logic [BYTE_W:0] expected_codeword[$];
    int unsigned errors;
    int unsigned results_seen;

    function new();
      low_lane = '0;
      high_lane = '0;
      data_count = 0;
      errors = 0;
      results_seen = 0;
    endfunction

    function logic [SYM_W-1:0] tap_product(int unsigned tap, logic [SYM_W-1:0] fb);
      if (fb == '0) begin
        return '0;
      end
      return FIELD_EXP[(ROOT_LOG[tap] + FIELD_LOG[fb]) % 15];
    endfunction

    function par_vec_t lane_advance(par_vec_t p, logic [SYM_W-1:0] sym);
      par_vec_t n;
      logic [SYM_W-1:0] fb;
      fb = sym ^ p[PAR_SYMS-1];
      for (int j = PAR_SYMS - 1; j > 0; j--) begin
        n[j] = p[j-1] ^ tap_product(j, fb);
      end
      n[0] = tap_product(0, fb);
      return n;
    endfunction

    // A byte equal to the top parity of both lanes gives zero feedback in both lanes.
    function logic [BYTE_W-1:0] top_parity();
      return {high_lane[PAR_SYMS-1], low_lane[PAR_SYMS-1]};
    endfunction

    function int unsigned pending();
      return expected_codeword.size();
    endfunction

    function void note_data_byte(logic [BYTE_W-1:0] b);
      low_lane = lane_advance(low_lane, b[SYM_W-1:0]);
      high_lane = lane_advance(high_lane, b[BYTE_W-1:SYM_W]);
      expected_codeword.push_back({1'b0, b});
      data_count++;
      if (data_count >= DATA_SYMBOLS) begin
        for (int j = PAR_SYMS - 1; j >= 0; j--) begin
          expected_codeword.push_back({(j == 0), high_lane[j], low_lane[j]});
        end
        low_lane = '0;
        high_lane = '0;
        data_count = 0;
      end
    endfunction

    function void check_code_byte(logic [BYTE_W-1:0] code, logic last);
      logic [BYTE_W:0] want;
      results_seen++;
      if (expected_codeword.size() == 0) begin
        $display("%0t: unexpected code byte: expected none, actual %02h end %0b",
                 $time, code, last);
        errors++;
        return;
      end
      want = expected_codeword.pop_front();
      if (code !== want[BYTE_W-1:0]) begin
        $display("%0t: code_byte mismatch: expected %02h, actual %02h",
                 $time, want[BYTE_W-1:0], code);
        errors++;
      end
      if (last !== want[BYTE_W]) begin
        $display("%0t: block_end mismatch: expected %0b, actual %0b",
                 $time, want[BYTE_W], last);
        errors++;
      end
    endfunction
  endclass

  logic clk;
  logic rst;
  logic in_valid;
  logic in_stall;
  logic [BYTE_W-1:0] data_byte;
  logic out_valid;
  logic out_stall;
  logic [BYTE_W-1:0] code_byte;
  logic block_end;

  rs_scoreboard board;
  bit no_gaps;
  int unsigned cycle_count;

  dual_lane_rs15_11_encoder u_dut (
    .clk       (clk),
    .rst       (rst),
    .in_valid  (in_valid),
    .in_stall  (in_stall),
    .data_byte (data_byte),
    .out_valid (out_valid),
    .out_stall (out_stall),
    .code_byte (code_byte),
    .block_end (block_end)
  );

  initial begin
    clk = 1'b0;
    forever #5 clk = ~clk;
  end

  initial begin
    cycle_count = 0;
    while (cycle_count < CYCLE_LIMIT) begin
      @(posedge clk);
      cycle_count++;
    end
    $display("Verification failed");
    $finish;
  end

  // Entered and left at a falling edge; returns once the byte has been transferred.
  task automatic send_byte(input logic [BYTE_W-1:0] b);
    int unsigned gap;
    gap = no_gaps ? 0 : $urandom_range(0, 7);
    if (gap > 0) begin
      in_valid <= 1'b0;
      repeat (gap) @(negedge clk);
    end
    in_valid <= 1'b1;
    data_byte <= b;
    do @(posedge clk); while (in_stall);
    board.note_data_byte(b);
    @(negedge clk);
  endtask

  task automatic send_random_byte();
    int unsigned pick;
    pick = $urandom_range(0, 15);
    if (pick < 2) begin
      send_byte(board.top_parity());
    end else if (pick == 2) begin
      send_byte('0);
    end else if (pick == 3) begin
      send_byte('1);
    end else begin
      send_byte(BYTE_W'($urandom_range(0, 255)));
    end
  endtask

  // Output side: random stalls per transfer, plus one long hold-off that backs up the block.
  initial begin
    int unsigned hold_cycles;
    bit long_hold_done;
    long_hold_done = 1'b0;
    out_stall = 1'b0;
    @(negedge clk);
    while (rst) @(negedge clk);
    forever begin
      if (!long_hold_done && board.results_seen >= 40) begin
        hold_cycles = LONG_HOLD;
        long_hold_done = 1'b1;
      end else begin
        hold_cycles = no_gaps ? 0 : $urandom_range(0, 7);
      end
      if (hold_cycles > 0) begin
        out_stall <= 1'b1;
        repeat (hold_cycles) @(negedge clk);
      end
      out_stall <= 1'b0;
      do @(posedge clk); while (!out_valid);
      @(negedge clk);
    end
  end

  always @(posedge clk) begin
    if (!rst && out_valid && !out_stall) begin
      board.check_code_byte(code_byte, block_end);
    end
  end

  initial begin
    board = new();
    no_gaps = 1'b0;
    rst = 1'b1;
    in_valid = 1'b0;
    data_byte = '0;
    repeat (5) @(posedge clk);
    @(negedge clk);
    rst <= 1'b0;
    @(negedge clk);

    // Field extremes and single-lane patterns, with zero feedback forced on a live register.
    send_byte(8'hff);
    send_byte(8'h00);
    send_byte(8'h0f);
    send_byte(8'hf0);
    send_byte(board.top_parity());
    send_byte(8'h01);
    send_byte(8'h80);
    send_byte(8'h55);
    send_byte(8'haa);
    send_byte(board.top_parity());
    send_byte(8'h12);
    // An all-zero codeword only ever shifts zeros through the parity.
    repeat (DATA_SYMBOLS) send_byte(8'h00);

    for (int i = 0; i < RANDOM_ITEMS; i++) begin
      if (i == 50) begin
        in_valid <= 1'b0;
        while (board.pending() != 0) @(negedge clk);
      end
      no_gaps = (i >= 70 && i < 90);
      send_random_byte();
    end
    in_valid <= 1'b0;
    no_gaps = 1'b0;

    while (board.pending() != 0) @(posedge clk);
    repeat (DRAIN_CYCLES) @(posedge clk);
    if (board.errors == 0 && board.pending() == 0) begin
      $display("Verification passed");
    end else begin
      $display("Verification failed");
    end
    $finish;
  end

endmodule
